// ===== rtl/rcbc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Raiden CBC cipher.
// Used by rcbc_key_sched, rcbc_round_unit and raiden_cbc_block_cipher.
package rcbc_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 16;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BLOCK_W         = 2 * WORD_W;
  localparam int unsigned NUM_KEY_WORDS   = 4;
  localparam int unsigned CFG_IDX_W       = 3;

  // Round function shift amounts and the key schedule shift mask.
  localparam int unsigned RF_SHL     = 9;
  localparam int unsigned RF_SHR     = 14;
  localparam logic [4:0]  SHIFT_MASK = 5'h1F;
  localparam logic [1:0]  SLOT_MASK  = 2'h3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd5;

  // Direction codes carried in tuser.
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [WORD_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic busy;
  } ks_status_t;

  function automatic logic [WORD_W-1:0] round_f(logic [WORD_W-1:0] sk, logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] s;
    s = sk + x;
    return (s << RF_SHL) ^ (sk - x) ^ (s >> RF_SHR);
  endfunction

  function automatic logic [WORD_W-1:0] sched_word(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1,
                                                   logic [WORD_W-1:0] k2, logic [WORD_W-1:0] k3);
    logic [4:0] sh;
    sh = k2[4:0] & SHIFT_MASK;
    return (k0 + k1) + ((k2 + k3) ^ (k0 << sh));
  endfunction

endpackage

// ===== rtl/raiden_cbc_block_cipher.sv =====
// Raiden 64-bit block cipher with a 128-bit key in CBC mode: top level with
// stream ports, configuration registers and the round sequencer.
// Depends on rcbc_pkg, rcbc_key_sched and rcbc_round_unit.
//
// Each transfer on the slave stream carries one 8-byte block and its
// direction; the block runs through ROUND_COUNT rounds of a single shared
// round unit, one full round per clock, then the CBC chaining is applied in
// the finish state, which waits for the output register to be free, before
// the result is registered on the master stream. No new block is accepted
// from the accepting edge until the finish state has handed its result on.
// The output register decouples the two sides, so a new block is accepted
// while a finished result still waits. Writing any of the six configuration
// registers reloads the chaining value from the IV registers at once and
// re-expands the round keys from the key words, one key per cycle, so slave
// tready stays low after the last write until the expansion is done. The
// tlast marker is passed through unchanged and does not reset the chain;
// encrypt and decrypt transfers share one chaining value. Writes to indexes
// beyond the IV registers are ignored.
module raiden_cbc_block_cipher #(
  parameter int unsigned ROUND_COUNT = rcbc_pkg::ROUND_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [rcbc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcbc_pkg::WORD_W-1:0]    cfg_data_i,
  // Slave stream: input blocks.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rcbc_pkg::BLOCK_W-1:0]   s_axis_tdata,  // [31:0] data_low, [63:32] data_high
  input  logic                           s_axis_tuser,  // [0] action
  input  logic                           s_axis_tlast,  // block_last
  // Master stream: processed blocks.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rcbc_pkg::BLOCK_W-1:0]   m_axis_tdata,  // [31:0] result_low, [63:32] result_high
  output logic                           m_axis_tlast   // result_last
);
  import rcbc_pkg::*;

  localparam int unsigned RIDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RIDX_W-1:0] LAST_IDX = RIDX_W'(ROUND_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  cfg_wr_t           cfg;
  ks_status_t        ks_status;
  logic [WORD_W-1:0] rk;
  logic [WORD_W-1:0] iv_low_q, iv_low_d;
  logic [WORD_W-1:0] iv_high_q, iv_high_d;
  logic [WORD_W-1:0] chain_low_q, chain_high_q;
  logic [WORD_W-1:0] b0_q, b1_q;
  logic [WORD_W-1:0] b0_nxt, b1_nxt;
  logic [WORD_W-1:0] ct_low_q, ct_high_q;
  logic [WORD_W-1:0] res_low, res_high;
  logic [RIDX_W-1:0] rnd_q;
  logic              decrypt_q;
  logic              last_q;
  logic              out_valid_q;
  logic [BLOCK_W-1:0] out_data_q;
  logic              out_last_q;
  logic              in_fire;
  logic              out_free;
  logic              last_round;
  logic              finish;
  logic              cfg_valid;
  logic [WORD_W-1:0] in_low, in_high;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;
  assign cfg_valid = cfg_we_i && (cfg_idx_i <= REG_IV_HIGH);

  assign in_low  = s_axis_tdata[WORD_W-1:0];
  assign in_high = s_axis_tdata[BLOCK_W-1:WORD_W];

  assign s_axis_tready = (state_q == ST_IDLE) && !ks_status.busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign last_round    = (rnd_q == (decrypt_q ? '0 : LAST_IDX));
  assign finish        = (state_q == ST_FIN) && out_free;

  rcbc_key_sched #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_key_sched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .rd_idx_i (rnd_q),
    .rk_o     (rk),
    .status_o (ks_status)
  );

  rcbc_round_unit u_round (
    .decrypt_i (decrypt_q),
    .rk_i      (rk),
    .b0_i      (b0_q),
    .b1_i      (b1_q),
    .b0_o      (b0_nxt),
    .b1_o      (b1_nxt)
  );

  // IV registers.
  always_comb begin
    iv_low_d  = iv_low_q;
    iv_high_d = iv_high_q;
    if (cfg_we_i && (cfg_idx_i == REG_IV_LOW)) begin
      iv_low_d = cfg_data_i;
    end
    if (cfg_we_i && (cfg_idx_i == REG_IV_HIGH)) begin
      iv_high_d = cfg_data_i;
    end
  end

  // Decryption XORs the chain after the rounds; encryption did it before.
  assign res_low  = (decrypt_q == ACT_DECRYPT) ? (b0_q ^ chain_low_q) : b0_q;
  assign res_high = (decrypt_q == ACT_DECRYPT) ? (b1_q ^ chain_high_q) : b1_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_RUN;
      ST_RUN:  if (last_round) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iv_low_q     <= '0;
      iv_high_q    <= '0;
      chain_low_q  <= '0;
      chain_high_q <= '0;
      out_valid_q  <= 1'b0;
      rnd_q        <= '0;
    end else begin
      state_q   <= state_d;
      iv_low_q  <= iv_low_d;
      iv_high_q <= iv_high_d;
      if (cfg_valid) begin
        chain_low_q  <= iv_low_d;
        chain_high_q <= iv_high_d;
      end else if (finish) begin
        // The chain always takes the ciphertext side of the block.
        chain_low_q  <= (decrypt_q == ACT_DECRYPT) ? ct_low_q  : b0_q;
        chain_high_q <= (decrypt_q == ACT_DECRYPT) ? ct_high_q : b1_q;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        rnd_q <= (s_axis_tuser == ACT_DECRYPT) ? LAST_IDX : '0;
      end else if (state_q == ST_RUN) begin
        rnd_q <= decrypt_q ? (rnd_q - 1'b1) : (rnd_q + 1'b1);
      end
    end
  end

  // Block datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      decrypt_q <= s_axis_tuser;
      last_q    <= s_axis_tlast;
      ct_low_q  <= in_low;
      ct_high_q <= in_high;
      if (s_axis_tuser == ACT_DECRYPT) begin
        b0_q <= in_low;
        b1_q <= in_high;
      end else begin
        b0_q <= in_low ^ chain_low_q;
        b1_q <= in_high ^ chain_high_q;
      end
    end else if (state_q == ST_RUN) begin
      b0_q <= b0_nxt;
      b1_q <= b1_nxt;
    end
    if (finish) begin
      out_data_q <= {res_high, res_low};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_fire_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN))
    else $error("accepted block did not start the round loop");

  a_last_round_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && last_round) |=> (state_q == ST_FIN))
    else $error("round loop did not end after the last round");

  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result appeared without a finished block");

  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) || ks_status.busy) |-> !s_axis_tready)
    else $error("input accepted while the core was busy");

endmodule

// ===== rtl/rcbc_key_sched.sv =====
// Key word registers and iterative round key expansion, one key per cycle.
// Depends on rcbc_pkg.
module rcbc_key_sched #(
  parameter int unsigned ROUND_COUNT = rcbc_pkg::ROUND_COUNT_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  rcbc_pkg::cfg_wr_t                                 cfg_i,
  input  logic [((ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1)-1:0] rd_idx_i,
  output logic [rcbc_pkg::WORD_W-1:0]                       rk_o,
  output rcbc_pkg::ks_status_t                              status_o
);
  import rcbc_pkg::*;

  localparam int unsigned RIDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RIDX_W-1:0] LAST_IDX = RIDX_W'(ROUND_COUNT - 1);

  logic [WORD_W-1:0] key_q [NUM_KEY_WORDS];
  logic [WORD_W-1:0] key_d [NUM_KEY_WORDS];
  logic [WORD_W-1:0] work_q [NUM_KEY_WORDS];
  logic [WORD_W-1:0] rk_q [ROUND_COUNT];
  logic [RIDX_W-1:0] cnt_q;
  logic              busy_q;
  logic              rebuild;
  logic              key_wr;
  logic [WORD_W-1:0] sk;
  logic [1:0]        slot;

  assign key_wr  = cfg_i.we && (cfg_i.idx <= REG_KEY_WORD3);
  assign rebuild = cfg_i.we && (cfg_i.idx <= REG_IV_HIGH);
  assign sk      = sched_word(work_q[0], work_q[1], work_q[2], work_q[3]);
  assign slot    = 2'(cnt_q) & SLOT_MASK;

  always_comb begin
    for (int i = 0; i < NUM_KEY_WORDS; i++) begin
      key_d[i] = key_q[i];
    end
    if (key_wr) begin
      key_d[cfg_i.idx[1:0]] = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEY_WORDS; i++) begin
        key_q[i] <= '0;
      end
      // The all-zero key expands to all-zero round keys.
      for (int i = 0; i < ROUND_COUNT; i++) begin
        rk_q[i] <= '0;
      end
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      for (int i = 0; i < NUM_KEY_WORDS; i++) begin
        key_q[i] <= key_d[i];
      end
      if (rebuild) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rk_q[cnt_q] <= sk;
        cnt_q       <= cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Working copy of the key words, overwritten slot by slot during expansion.
  always_ff @(posedge clk_i) begin
    if (rebuild) begin
      for (int i = 0; i < NUM_KEY_WORDS; i++) begin
        work_q[i] <= key_d[i];
      end
    end else if (busy_q) begin
      work_q[slot] <= sk;
    end
  end

  assign rk_o          = rk_q[rd_idx_i];
  assign status_o.busy = busy_q;

endmodule

// ===== rtl/rcbc_round_unit.sv =====
// One full Feistel round (both half rounds) in either direction.
// Depends on rcbc_pkg.
module rcbc_round_unit (
  input  logic                        decrypt_i,
  input  logic [rcbc_pkg::WORD_W-1:0] rk_i,
  input  logic [rcbc_pkg::WORD_W-1:0] b0_i,
  input  logic [rcbc_pkg::WORD_W-1:0] b1_i,
  output logic [rcbc_pkg::WORD_W-1:0] b0_o,
  output logic [rcbc_pkg::WORD_W-1:0] b1_o
);
  import rcbc_pkg::*;

  logic [WORD_W-1:0] enc_b0;
  logic [WORD_W-1:0] dec_b1;

  // Encryption updates b0 first; decryption undoes b1 first.
  assign enc_b0 = b0_i + round_f(rk_i, b1_i);
  assign dec_b1 = b1_i - round_f(rk_i, b0_i);

  always_comb begin
    if (decrypt_i) begin
      b1_o = dec_b1;
      b0_o = b0_i - round_f(rk_i, dec_b1);
    end else begin
      b0_o = enc_b0;
      b1_o = b1_i + round_f(rk_i, enc_b0);
    end
  end

endmodule
